/* rtl/assert_macros.svh */
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property that must hold at every clock edge outside reset.
`define AST_HOLDS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define AST_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`else

`define AST_HOLDS(label, clk, rst, prop, msg)
`define AST_NEVER(label, clk, rst, cond, msg)

`endif

`endif

/* rtl/abfc_pkg.sv */
// Types, constants and threshold functions of the audio backlog flow control.
package abfc_pkg;

   localparam int TIME_BITS_DEF = 48;
   localparam int NOW_W         = 48;
   localparam int BYTES_W       = 48;
   localparam int COUNT_W       = 16;
   localparam int CAP_W         = 20;
   localparam int MS_W          = 16;
   localparam int LIM_W         = 23;
   localparam int Y_W           = 26;  // rounded-up backlog numerator, < 65536000
   localparam int RECIP_W       = 27;
   localparam int DIV_SHIFT     = Y_W + 10;

   localparam int US_PER_MS     = 1000;
   localparam int CAP_MIN       = 120;
   localparam int PAUSE_CAP     = 5000;
   localparam int RESUME_CAP    = 1500;
   localparam int RESEND_US     = 2000 * US_PER_MS;
   localparam int LOW_BACKLOG_X = 255 * US_PER_MS;    // backlog below 256 ms
   localparam int SAT_X         = 65535 * US_PER_MS;  // backlog above 65535 ms

   // limits for the reset capacity of 8192 ms
   localparam logic [LIM_W-1:0] PAUSE_LIM_RST  = LIM_W'((PAUSE_CAP - 1) * US_PER_MS);
   localparam logic [LIM_W-1:0] RESUME_LIM_RST = LIM_W'(RESUME_CAP * US_PER_MS);

   // ceil(2^DIV_SHIFT / 1000): exact floor division for any Y_W-bit value
   localparam logic [RECIP_W-1:0] MS_RECIP =
      RECIP_W'(((64'd1 << DIV_SHIFT) + 64'd999) / 64'd1000);

   localparam logic [1:0] REPEAT_COUNT = 2'd2;

   typedef enum logic [1:0] {
      FUNC_DELIVER = 2'd0,
      FUNC_TICK    = 2'd1,
      FUNC_ARM     = 2'd2,
      FUNC_DISARM  = 2'd3
   } func_type;

   // 1000 * (min(5000, cap*5/8) - 1): backlog >= pause threshold <=> x > this
   function automatic logic [LIM_W-1:0] pause_limit(input logic [CAP_W-1:0] cap);
      logic [CAP_W+2:0] cap5;
      logic [CAP_W-1:0] cp;
      logic [12:0]      p;
      cap5 = (CAP_W+3)'(cap) + ((CAP_W+3)'(cap) << 2);
      cp   = cap5[CAP_W+2:3];
      p    = (cp < CAP_W'(PAUSE_CAP)) ? 13'(cp) : 13'(PAUSE_CAP);
      return LIM_W'(13'(p - 13'd1)) * LIM_W'(US_PER_MS);
   endfunction

   // 1000 * min(1500, cap*3/16): backlog <= resume threshold <=> x <= this
   function automatic logic [LIM_W-1:0] resume_limit(input logic [CAP_W-1:0] cap);
      logic [CAP_W+1:0] cap3;
      logic [CAP_W-3:0] cr;
      logic [10:0]      r;
      cap3 = (CAP_W+2)'(cap) + ((CAP_W+2)'(cap) << 1);
      cr   = cap3[CAP_W+1:4];
      r    = (cr < (CAP_W-2)'(RESUME_CAP)) ? 11'(cr) : 11'(RESUME_CAP);
      return LIM_W'(r) * LIM_W'(US_PER_MS);
   endfunction

endpackage

/* rtl/audio_backlog_flow_control_unit.sv */
// Top level: event-driven pause/resume flow control from an audio backlog estimate.
//
//   channel  | ports                                      | dir | notes
//   ---------+--------------------------------------------+-----+--------------------------
//   req      | req_valid/ready, func, now_us, byte_count  | in  | one event per transfer
//   rsp      | rsp_valid/ready, flow_state, backlog_ms    | out | zero or one per event
//   csr      | csr_wr_en, csr_wr_data                     | in  | buffer capacity, no wait
//
// One event per cycle, sustained while rsp is not stalled. A message reaches rsp
// after its event's transfer through the input register, the state update, then
// the divide-by-1000 multiplier stage feeding the output register.
// Reset (synchronous) clears all flow state and sets the thresholds for a
// capacity of 8192 ms.
// rsp_ready low stalls the output; the input and middle stages keep filling,
// so req_ready drops only once all three stages hold work.
`include "assert_macros.svh"

module audio_backlog_flow_control_unit import abfc_pkg::*; #(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_func,
   input  logic [NOW_W-1:0]   req_now_us,
   input  logic [COUNT_W-1:0] req_byte_count,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_flow_state,
   output logic [MS_W-1:0]    rsp_backlog_ms,
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data
);

   localparam int HAVE_W = BYTES_W - 5;  // delivered bytes / 32
   localparam int XW     = ((TIME_BITS > HAVE_W + 10) ? TIME_BITS : HAVE_W + 10) + 2;

   // input register
   logic               s0_v_ff,     s0_v_in;
   func_type           s0_func_ff;
   logic [NOW_W-1:0]   s0_now_ff;
   logic [COUNT_W-1:0] s0_count_ff;

   // flow state
   logic                 armed_ff,  armed_in;
   logic                 paused_ff, paused_in;
   logic [1:0]           rep_ff,    rep_in;
   logic [TIME_BITS-1:0] base_ff,   base_in;
   logic [BYTES_W-1:0]   deliv_ff,  deliv_in;
   logic [TIME_BITS-1:0] last_ff,   last_in;
   logic [LIM_W-1:0]     pause_lim_ff,  pause_lim_in;
   logic [LIM_W-1:0]     resume_lim_ff, resume_lim_in;

   // middle stage and output register
   logic           s1_v_ff, s1_v_in;
   logic           s1_flow_ff;
   logic [Y_W-1:0] s1_y_ff;
   logic           rsp_v_ff, rsp_v_in;
   logic           rsp_flow_ff;

   // pipeline advance
   logic s0_go, s1_go, s1_free, s2_free;

   // backlog arithmetic
   logic [TIME_BITS-1:0] now_t;
   logic [TIME_BITS-1:0] el_d;
   logic [XW-1:0]        have_x, have1000;
   logic signed [XW-1:0] x;        // 1000*backlog_ms rounded: backlog = ceil(x/1000)
   logic                 pos, gt_pause, le_resume, low_backlog, since_ok;
   logic [BYTES_W:0]     deliv_sum;
   logic [CAP_W-1:0]     cap_sat;

   logic           emit, emit_flow;
   logic [Y_W-1:0] emit_y, tick_y;

   assign s2_free   = !rsp_v_ff || rsp_ready;
   assign s1_free   = !s1_v_ff || s2_free;
   assign s1_go     = s1_v_ff && s2_free;
   assign s0_go     = s0_v_ff && s1_free;
   assign req_ready = !s0_v_ff || s1_free;

   // microseconds since baseline, with time going backwards counted as zero
   assign now_t    = TIME_BITS'(s0_now_ff);
   assign el_d     = (now_t > base_ff) ? now_t - base_ff : '0;
   assign have_x   = XW'(deliv_ff[BYTES_W-1:5]);
   assign have1000 = (have_x << 10) - (have_x << 4) - (have_x << 3);
   assign x        = signed'(have1000 - XW'(el_d));

   // threshold tests done on the scaled value, no divide in the loop
   assign pos         = x > 0;
   assign gt_pause    = x > signed'(XW'(pause_lim_ff));
   assign le_resume   = x <= signed'(XW'(resume_lim_ff));
   assign low_backlog = x <= signed'(XW'(LOW_BACKLOG_X));
   assign since_ok    = (now_t > last_ff) && ((now_t - last_ff) >= TIME_BITS'(RESEND_US));

   // numerator for floor division: zero, saturated, or x + 999
   always_comb begin
      if (!pos) begin
         tick_y = '0;
      end else if (x > signed'(XW'(SAT_X))) begin
         tick_y = Y_W'(SAT_X);
      end else begin
         tick_y = x[Y_W-1:0] + Y_W'(US_PER_MS - 1);
      end
   end

   assign deliv_sum = {1'b0, deliv_ff} + (BYTES_W+1)'(s0_count_ff);
   assign cap_sat   = (csr_wr_data < CAP_W'(CAP_MIN)) ? CAP_W'(CAP_MIN) : csr_wr_data;

   // event handling
   always_comb begin
      armed_in  = armed_ff;
      paused_in = paused_ff;
      rep_in    = rep_ff;
      base_in   = base_ff;
      deliv_in  = deliv_ff;
      last_in   = last_ff;
      emit      = 1'b0;
      emit_flow = 1'b0;
      emit_y    = '0;
      if (s0_go) begin
         case (s0_func_ff)
            FUNC_DELIVER: begin
               deliv_in = deliv_sum[BYTES_W] ? '1 : deliv_sum[BYTES_W-1:0];
            end
            FUNC_ARM: begin
               armed_in  = 1'b1;
               paused_in = 1'b0;
               rep_in    = '0;
               base_in   = now_t;
               last_in   = now_t;
               deliv_in  = '0;
            end
            FUNC_DISARM: begin
               if (armed_ff) begin
                  armed_in  = 1'b0;
                  paused_in = 1'b0;
                  rep_in    = '0;
                  emit      = paused_ff;  // closing resume, backlog 0
               end
            end
            FUNC_TICK: begin
               if (armed_ff) begin
                  if (!pos) begin
                     base_in  = now_t;
                     deliv_in = '0;
                  end
                  if (!paused_ff && gt_pause) begin
                     paused_in = 1'b1;
                     rep_in    = REPEAT_COUNT;
                     emit      = 1'b1;
                  end else if (paused_ff && le_resume) begin
                     paused_in = 1'b0;
                     rep_in    = REPEAT_COUNT;
                     emit      = 1'b1;
                  end else if (rep_ff != '0) begin
                     rep_in = rep_ff - 2'd1;
                     emit   = 1'b1;
                  end else if (since_ok) begin
                     emit = paused_ff || low_backlog;
                  end
                  if (emit) begin
                     last_in = now_t;
                  end
                  emit_flow = paused_in;
                  emit_y    = tick_y;
               end
            end
            default: begin
            end
         endcase
      end
   end

   assign pause_lim_in  = csr_wr_en ? pause_limit(cap_sat) : pause_lim_ff;
   assign resume_lim_in = csr_wr_en ? resume_limit(cap_sat) : resume_lim_ff;

   assign s0_v_in  = (req_valid && req_ready) ? 1'b1 : (s0_go ? 1'b0 : s0_v_ff);
   assign s1_v_in  = emit ? 1'b1 : (s1_go ? 1'b0 : s1_v_ff);
   assign rsp_v_in = s1_go ? 1'b1 : (rsp_ready ? 1'b0 : rsp_v_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_v_ff       <= 1'b0;
         s1_v_ff       <= 1'b0;
         rsp_v_ff      <= 1'b0;
         armed_ff      <= 1'b0;
         paused_ff     <= 1'b0;
         rep_ff        <= '0;
         base_ff       <= '0;
         deliv_ff      <= '0;
         last_ff       <= '0;
         pause_lim_ff  <= PAUSE_LIM_RST;
         resume_lim_ff <= RESUME_LIM_RST;
      end else begin
         s0_v_ff       <= s0_v_in;
         s1_v_ff       <= s1_v_in;
         rsp_v_ff      <= rsp_v_in;
         armed_ff      <= armed_in;
         paused_ff     <= paused_in;
         rep_ff        <= rep_in;
         base_ff       <= base_in;
         deliv_ff      <= deliv_in;
         last_ff       <= last_in;
         pause_lim_ff  <= pause_lim_in;
         resume_lim_ff <= resume_lim_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s0_func_ff  <= func_type'(req_func);
         s0_now_ff   <= req_now_us;
         s0_count_ff <= req_byte_count;
      end
      if (emit) begin
         s1_flow_ff <= emit_flow;
         s1_y_ff    <= emit_y;
      end
      if (s1_go) begin
         rsp_flow_ff <= s1_flow_ff;
      end
   end

   abfc_ms_div u_ms_div (
      .clock (clock),
      .load  (s1_go),
      .y     (s1_y_ff),
      .ms    (rsp_backlog_ms)
   );

   assign rsp_valid      = rsp_v_ff;
   assign rsp_flow_state = rsp_flow_ff;

   `AST_HOLDS(a_paused_needs_armed, clock, reset, !armed_ff |-> !paused_ff, "paused while disarmed")
   `AST_NEVER(a_repeat_range, clock, reset, rep_ff == 2'd3, "repeat count out of range")
   `AST_HOLDS(a_tick_send_time, clock, reset, (emit && s0_func_ff == FUNC_TICK) |=> (last_ff == $past(now_t)), "send time not recorded")
   `AST_HOLDS(a_tick_flow_state, clock, reset, (emit && s0_func_ff == FUNC_TICK) |=> (s1_flow_ff == paused_ff), "message state differs from flow state")
   `AST_HOLDS(a_disarm_resume, clock, reset, (emit && s0_func_ff == FUNC_DISARM) |=> (!s1_flow_ff && s1_y_ff == '0), "disarm message not a zero resume")

endmodule

/* rtl/abfc_ms_div.sv */
// Backlog divide by 1000 through a reciprocal multiply, registered.
module abfc_ms_div import abfc_pkg::*; (
   input  logic            clock,
   input  logic            load,
   input  logic [Y_W-1:0]  y,
   output logic [MS_W-1:0] ms
);

   logic [Y_W+RECIP_W-1:0] prod;
   logic [MS_W-1:0]        ms_ff;
   logic [MS_W-1:0]        ms_in;

   assign prod  = (Y_W+RECIP_W)'(y) * (Y_W+RECIP_W)'(MS_RECIP);
   assign ms_in = prod[DIV_SHIFT +: MS_W];  // quotient never exceeds 65535

   always_ff @(posedge clock) begin
      if (load) begin
         ms_ff <= ms_in;
      end
   end

   assign ms = ms_ff;

endmodule
